### hdl/rps_pkg.sv
package rps_pkg;

	localparam int MAX_STEPS = 16;
	localparam int IDX_W     = $clog2(MAX_STEPS);
	localparam int STEP_W    = $clog2(MAX_STEPS + 1);

	localparam int TEMP_W    = 14;
	localparam int TICKS_W   = 16;
	localparam int MARGIN_W  = 12;
	localparam int ELAPSED_W = 32;

	// operation codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;
	localparam logic [1:0] OP_WRITE = 2'd3;

	// oven modes
	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_WARMUP  = 2'd1;
	localparam logic [1:0] MODE_PROFILE = 2'd2;
	localparam logic [1:0] MODE_COOLING = 2'd3;

	// start status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_REJECTED = 2'd1;
	localparam logic [1:0] ST_TOO_HOT  = 2'd2;

	// register indexes
	localparam logic [2:0] REG_PROFILE_SELECTED = 3'd0;
	localparam logic [2:0] REG_NUM_STEPS        = 3'd1;
	localparam logic [2:0] REG_MAX_START_TEMP   = 3'd2;
	localparam logic [2:0] REG_WARMUP_TEMP      = 3'd3;
	localparam logic [2:0] REG_WARMUP_TICKS     = 3'd4;
	localparam logic [2:0] REG_COOLING_TEMP     = 3'd5;
	localparam logic [2:0] REG_FAN_MARGIN       = 3'd6;

	typedef struct packed {
		logic [1:0]              operation;
		logic signed [TEMP_W-1:0] sample_temp;
		logic [3:0]              entry_index;
		logic signed [TEMP_W-1:0] entry_temp;
		logic [TICKS_W-1:0]      entry_ticks;
	} in_word_t;

	typedef struct packed {
		logic [ELAPSED_W-1:0]    elapsed_ticks;
		logic [TICKS_W-1:0]      remaining_ticks;
		logic [4:0]              step_number;
		logic                    pid_enable;
		logic                    fan_on;
		logic signed [TEMP_W-1:0] target_temp;
		logic [1:0]              mode;
		logic [1:0]              status;
	} out_word_t;

endpackage

### hdl/reflow_profile_sequencer_top.sv
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+---------------------------------------
// s_axis   | in        | s_tvalid / s_tready     | s_tuser op, s_tdata sample/entry (48b)
// m_axis   | out       | m_tvalid / m_tready     | m_tdata result word (80b)
// apb      | in        | psel / penable / pready | seven 32-bit config registers
//
// one word is accepted per cycle while s_tready is high; its result passes through the
// input register, then the state update and result register in one pass
// reset clears mode, counters, target, fan and last sample and sets the config registers to their defaults;
// the step table is not reset and holds garbage until written
// a stalled result holds in the output register while the input register still
// takes one more word; the input side stalls only when both are full
module reflow_profile_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // sample_temp[13:0], entry_index[17:14], entry_temp[31:18],
	                              // entry_ticks[47:32]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // status[1:0], mode[3:2], target_temp[17:4], fan_on[18],
	                              // pid_enable[19], step_number[24:20],
	                              // remaining_ticks[40:25], elapsed_ticks[72:41], zero above
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int TW = rps_pkg::TEMP_W;
	localparam int KW = rps_pkg::TICKS_W;
	localparam int SW = rps_pkg::STEP_W;
	localparam int IW = rps_pkg::IDX_W;

	// config registers
	logic                 profile_selected_q;
	logic [4:0]           num_steps_q;
	logic signed [TW-1:0] max_start_temp_q;
	logic signed [TW-1:0] warmup_temp_q;
	logic [KW-1:0]        warmup_ticks_q;
	logic signed [TW-1:0] cooling_temp_q;
	logic [rps_pkg::MARGIN_W-1:0] fan_margin_q;

	// oven state
	logic [1:0]           mode_q;
	logic [SW-1:0]        step_q;
	logic [KW-1:0]        remaining_q;
	logic [rps_pkg::ELAPSED_W-1:0] elapsed_q;
	logic signed [TW-1:0] target_q;
	logic                 fan_q;
	logic signed [TW-1:0] last_sample_q;

	// step table, read at the current step
	logic signed [TW-1:0] step_temps_q [rps_pkg::MAX_STEPS];
	logic [KW-1:0]        step_lengths_q [rps_pkg::MAX_STEPS];

	// pipeline
	logic                 valid_s1;
	rps_pkg::in_word_t    word_s1;
	logic                 out_valid_q;
	rps_pkg::out_word_t   out_q;
	logic                 advance;

	logic cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[4:2];

	always_comb begin
		unique case (cfg_idx)
			rps_pkg::REG_PROFILE_SELECTED: prdata = {31'd0, profile_selected_q};
			rps_pkg::REG_NUM_STEPS:        prdata = {27'd0, num_steps_q};
			rps_pkg::REG_MAX_START_TEMP:   prdata = {{(32-TW){max_start_temp_q[TW-1]}},
			                                        max_start_temp_q};
			rps_pkg::REG_WARMUP_TEMP:      prdata = {{(32-TW){warmup_temp_q[TW-1]}},
			                                        warmup_temp_q};
			rps_pkg::REG_WARMUP_TICKS:     prdata = {{(32-KW){1'b0}}, warmup_ticks_q};
			rps_pkg::REG_COOLING_TEMP:     prdata = {{(32-TW){cooling_temp_q[TW-1]}},
			                                        cooling_temp_q};
			rps_pkg::REG_FAN_MARGIN:       prdata = {{(32-rps_pkg::MARGIN_W){1'b0}},
			                                        fan_margin_q};
			default:                       prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile_selected_q <= 1'b0;
			num_steps_q        <= 5'd0;
			max_start_temp_q   <= TW'(200);
			warmup_temp_q      <= TW'(120);
			warmup_ticks_q     <= KW'(120);
			cooling_temp_q     <= TW'(400);
			fan_margin_q       <= rps_pkg::MARGIN_W'(60);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				rps_pkg::REG_PROFILE_SELECTED: profile_selected_q <= pwdata[0];
				rps_pkg::REG_NUM_STEPS:        num_steps_q        <= pwdata[4:0];
				rps_pkg::REG_MAX_START_TEMP:   max_start_temp_q   <= pwdata[TW-1:0];
				rps_pkg::REG_WARMUP_TEMP:      warmup_temp_q      <= pwdata[TW-1:0];
				rps_pkg::REG_WARMUP_TICKS:     warmup_ticks_q     <= pwdata[KW-1:0];
				rps_pkg::REG_COOLING_TEMP:     cooling_temp_q     <= pwdata[TW-1:0];
				rps_pkg::REG_FAN_MARGIN:       fan_margin_q  <= pwdata[rps_pkg::MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// input register moves on when the result register is free or draining
	assign advance  = ~out_valid_q | m_tready;
	assign s_tready = ~valid_s1 | advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			word_s1.operation   <= s_tuser;
			word_s1.sample_temp <= s_tdata[13:0];
			word_s1.entry_index <= s_tdata[17:14];
			word_s1.entry_temp  <= s_tdata[31:18];
			word_s1.entry_ticks <= s_tdata[47:32];
		end
	end

	// single pass of the sequencer
	logic                 fire;
	logic [1:0]           mode_n;
	logic [SW-1:0]        step_n;
	logic [KW-1:0]        rem_n;
	logic [rps_pkg::ELAPSED_W-1:0] elapsed_n;
	logic signed [TW-1:0] target_n;
	logic                 fan_n;
	logic signed [TW-1:0] sample_n;
	logic [1:0]           status_n;
	logic                 pid_n;

	logic [SW-1:0]        limit;
	logic [IW-1:0]        rd_idx;
	logic signed [TW-1:0] rd_temp;
	logic [KW-1:0]        rd_len;
	logic                 in_profile;
	logic signed [TW+1:0] fan_thresh;
	logic signed [TW-1:0] samp;

	assign fire    = valid_s1 & advance;
	assign samp    = word_s1.sample_temp;
	assign limit   = (num_steps_q > 5'(rps_pkg::MAX_STEPS)) ? SW'(rps_pkg::MAX_STEPS)
	                                                         : SW'(num_steps_q);
	assign rd_idx  = step_q[IW-1:0];
	assign rd_temp = step_temps_q[rd_idx];
	assign rd_len  = step_lengths_q[rd_idx];

	always_comb begin
		mode_n     = mode_q;
		step_n     = step_q;
		rem_n      = remaining_q;
		elapsed_n  = elapsed_q;
		target_n   = target_q;
		fan_n      = fan_q;
		sample_n   = last_sample_q;
		status_n   = rps_pkg::ST_OK;
		pid_n      = 1'b0;
		in_profile = 1'b0;
		fan_thresh = '0;

		unique case (word_s1.operation)
			rps_pkg::OP_TICK: begin
				sample_n = samp;
				pid_n    = 1'b1;
				// warm-up holds the countdown until the oven is warm enough
				if (mode_q == rps_pkg::MODE_WARMUP) begin
					target_n = warmup_temp_q;
					if (remaining_q != '0) begin
						if (samp >= warmup_temp_q) begin
							rem_n = remaining_q - KW'(1);
						end
					end else begin
						mode_n     = rps_pkg::MODE_PROFILE;
						in_profile = 1'b1;
					end
				end
				if (mode_q == rps_pkg::MODE_PROFILE) begin
					in_profile = 1'b1;
				end
				if (in_profile) begin
					if (remaining_q == '0 && step_q >= limit) begin
						mode_n = rps_pkg::MODE_COOLING;
					end else begin
						if (remaining_q == '0) begin
							// zero-length step lasts one tick
							rem_n    = (rd_len == '0) ? '0 : rd_len - KW'(1);
							target_n = rd_temp;
							step_n   = step_q + SW'(1);
						end else begin
							rem_n = remaining_q - KW'(1);
						end
						fan_thresh = {{2{target_n[TW-1]}}, target_n}
						           + $signed({{(TW+2-rps_pkg::MARGIN_W){1'b0}}, fan_margin_q});
						fan_n = ($signed({{2{samp[TW-1]}}, samp}) > fan_thresh);
					end
				end
				if (mode_q == rps_pkg::MODE_COOLING) begin
					target_n = cooling_temp_q;
					fan_n    = 1'b1;
					if (samp <= cooling_temp_q) begin
						mode_n   = rps_pkg::MODE_IDLE;
						target_n = '0;
						fan_n    = 1'b0;
						pid_n    = 1'b0;
					end
				end
				if (pid_n && elapsed_q != '1) begin
					elapsed_n = elapsed_q + rps_pkg::ELAPSED_W'(1);
				end
			end
			rps_pkg::OP_START: begin
				if (!profile_selected_q || mode_q != rps_pkg::MODE_IDLE) begin
					status_n = rps_pkg::ST_REJECTED;
				end else if (last_sample_q > max_start_temp_q) begin
					status_n = rps_pkg::ST_TOO_HOT;
				end else begin
					step_n    = '0;
					rem_n     = warmup_ticks_q;
					elapsed_n = '0;
					mode_n    = rps_pkg::MODE_WARMUP;
				end
			end
			rps_pkg::OP_STOP: begin
				mode_n   = rps_pkg::MODE_IDLE;
				target_n = '0;
				fan_n    = 1'b0;
			end
			rps_pkg::OP_WRITE: begin
				// table write handled below
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= rps_pkg::MODE_IDLE;
			step_q        <= '0;
			remaining_q   <= '0;
			elapsed_q     <= '0;
			target_q      <= '0;
			fan_q         <= 1'b0;
			last_sample_q <= '0;
		end else if (fire) begin
			mode_q        <= mode_n;
			step_q        <= step_n;
			remaining_q   <= rem_n;
			elapsed_q     <= elapsed_n;
			target_q      <= target_n;
			fan_q         <= fan_n;
			last_sample_q <= sample_n;
		end
	end

	// step table, written in order with the other items
	always_ff @(posedge clk) begin
		if (fire && word_s1.operation == rps_pkg::OP_WRITE) begin
			step_temps_q[word_s1.entry_index[IW-1:0]]   <= word_s1.entry_temp;
			step_lengths_q[word_s1.entry_index[IW-1:0]] <= word_s1.entry_ticks;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.status          <= status_n;
			out_q.mode            <= mode_n;
			out_q.target_temp     <= target_n;
			out_q.fan_on          <= fan_n;
			out_q.pid_enable      <= pid_n;
			out_q.step_number     <= 5'(step_n);
			out_q.remaining_ticks <= rem_n;
			out_q.elapsed_ticks   <= elapsed_n;
		end
	end

	// step count never runs past the table
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= SW'(rps_pkg::MAX_STEPS))
		else $error("step counter beyond table");

	// an idle oven has fan off and no target
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == rps_pkg::MODE_IDLE) |-> (!fan_q && target_q == '0))
		else $error("idle oven with fan or target set");

	// every processed word lands in the result register
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed word lost");

	// a rejected start leaves the mode untouched
	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && status_n != rps_pkg::ST_OK) |=> (mode_q == $past(mode_q)))
		else $error("rejected start changed mode");

endmodule
